// ===== hdl/mbbcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbbcd_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int INDEX_W      = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = INDEX_W + 1;
    localparam int COORD_W      = 24;
    localparam int VERTEX_W     = 3 * COORD_W;
    localparam int DIAG_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int REM_W        = DIAG_W + 2;
    localparam int ROOT_STEPS   = SUM_W / 2;
    localparam int STEP_W       = $clog2(ROOT_STEPS);

    // The visited bitmap is kept as rows of bits so that it can be swept quickly.
    localparam int VIS_WORD     = 32;
    localparam int VIS_BIT_W    = $clog2(VIS_WORD);
    localparam int VIS_ROWS     = MAX_VERTICES / VIS_WORD;
    localparam int VIS_ROW_W    = INDEX_W - VIS_BIT_W;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = '0;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_CORNER = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW   = 2'd1;
    localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

    localparam logic [COUNT_W-1:0] MIN_DISTINCT = COUNT_W'(3);

    localparam logic signed [COORD_W-1:0] COORD_MOST_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SQUARE,
        ST_ROOT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/mesh_bounding_box_center_diagonal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Mesh bounding box centre and diagonal.
// Input words are taken on a rising edge with start high and busy low. A word with
// cmd = load writes the three coordinates into vertex table slot vertex_index; a word
// with cmd = corner references a vertex of the current face list. While busy is low,
// loads and corners are taken one a cycle, since each needs one table read and one
// read-modify-write of a bitmap row, with the last written row forwarded to the
// corner behind it. A corner with last_corner set closes the list: busy rises at
// once and the result appears for one cycle with done high. An error result is
// registered straight from the decode of that corner; a good result first goes
// through squaring (one shared multiplier) and then the bit-serial square root.
// The result cannot be held off; it must be taken in the cycle that done is high.
// After each result, and after reset, the visited bitmap is swept clear one row per
// cycle with busy high. Reset also clears vertex_count and the list state;
// the vertex table holds nothing meaningful until it is loaded.
// The user must write vertex_count over the APB port while idle; it is not enforced.
module mesh_bounding_box_center_diagonal (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         start,
    output logic                                        busy,
    input  wire                                         cmd,
    input  wire  [mbbcd_pkg::INDEX_W-1:0]               vertex_index,
    input  wire  signed [mbbcd_pkg::COORD_W-1:0]        coord_x,
    input  wire  signed [mbbcd_pkg::COORD_W-1:0]        coord_y,
    input  wire  signed [mbbcd_pkg::COORD_W-1:0]        coord_z,
    input  wire                                         last_corner,
    output logic                                        done,
    output logic signed [mbbcd_pkg::COORD_W-1:0]        center_x,
    output logic signed [mbbcd_pkg::COORD_W-1:0]        center_y,
    output logic signed [mbbcd_pkg::COORD_W-1:0]        center_z,
    output logic [mbbcd_pkg::DIAG_W-1:0]                diagonal_length,
    output logic [1:0]                                  status,
    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire  [mbbcd_pkg::APB_ADDR_W-1:0]            paddr,
    input  wire  [mbbcd_pkg::APB_DATA_W-1:0]            pwdata,
    output logic [mbbcd_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                        pready
);

    localparam int CW = mbbcd_pkg::COORD_W;

    // Memories.
    logic [mbbcd_pkg::VERTEX_W-1:0] vtab_mem [mbbcd_pkg::MAX_VERTICES];
    logic [mbbcd_pkg::VIS_WORD-1:0] vis_mem  [mbbcd_pkg::VIS_ROWS];

    logic [mbbcd_pkg::VERTEX_W-1:0] vt_rd_reg;
    logic [mbbcd_pkg::VIS_WORD-1:0] vis_rd_reg;

    logic                            vis_we;
    logic [mbbcd_pkg::VIS_ROW_W-1:0] vis_waddr;
    logic [mbbcd_pkg::VIS_WORD-1:0]  vis_wdata;

    // Control and list state.
    mbbcd_pkg::state_t state_reg, state_next;
    logic [mbbcd_pkg::VIS_ROW_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [mbbcd_pkg::COUNT_W-1:0]   vcount_reg;

    logic                            s1_valid_reg, s1_valid_next;
    logic [mbbcd_pkg::INDEX_W-1:0]   s1_index_reg;
    logic                            s1_last_reg;

    logic                            fwd_valid_reg, fwd_valid_next;
    logic [mbbcd_pkg::VIS_ROW_W-1:0] fwd_row_reg;
    logic [mbbcd_pkg::VIS_WORD-1:0]  fwd_data_reg;

    logic [mbbcd_pkg::COUNT_W-1:0]   dcount_reg, dcount_next;
    logic                            range_err_reg, range_err_next;
    logic signed [CW-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [CW-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [CW-1:0] min_x_next, min_y_next, min_z_next;
    logic signed [CW-1:0] max_x_next, max_y_next, max_z_next;

    // Diagonal datapath.
    logic [2:0]                       sq_cnt_reg, sq_cnt_next;
    logic [CW-1:0]                    ext_reg, ext_next;
    logic [mbbcd_pkg::SQ_W-1:0]       sq_reg, sq_next;
    logic [mbbcd_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [mbbcd_pkg::SUM_W-1:0]      rad_reg, rad_next;
    logic [mbbcd_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [mbbcd_pkg::DIAG_W-1:0]     root_reg, root_next;
    logic [mbbcd_pkg::STEP_W-1:0]     iter_reg, iter_next;

    // Result registers.
    logic                             done_reg, done_next;
    logic signed [CW-1:0]             cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic [mbbcd_pkg::DIAG_W-1:0]     diag_reg, diag_next;
    logic [1:0]                       status_reg, status_next;

    logic accept;
    logic cfg_write;

    // Stage one decode.
    logic [mbbcd_pkg::VIS_WORD-1:0] row;
    logic                           seen;
    logic                           in_range;
    logic signed [CW-1:0]           vx, vy, vz;

    logic signed [CW:0]             axis_max, axis_min, axis_diff;
    logic signed [CW:0]             sum_x, sum_y, sum_z;
    logic [mbbcd_pkg::REM_W+1:0]    rem_trial, root_trial;
    logic [mbbcd_pkg::SUM_W-1:0]    sum_final;

    assign busy   = (state_reg != mbbcd_pkg::ST_RUN) || (s1_valid_reg && s1_last_reg);
    assign accept = start && !busy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[mbbcd_pkg::APB_ADDR_W-1:2] == mbbcd_pkg::REG_VERTEX_COUNT);
    assign prdata    = (paddr[mbbcd_pkg::APB_ADDR_W-1:2] == mbbcd_pkg::REG_VERTEX_COUNT)
                     ? {{(mbbcd_pkg::APB_DATA_W-mbbcd_pkg::COUNT_W){1'b0}}, vcount_reg}
                     : '0;

    assign done            = done_reg;
    assign center_x        = cx_reg;
    assign center_y        = cy_reg;
    assign center_z        = cz_reg;
    assign diagonal_length = diag_reg;
    assign status          = status_reg;

    always_ff @(posedge clk)
    begin
        if (accept && cmd == mbbcd_pkg::CMD_LOAD)
        begin
            vtab_mem[vertex_index] <= {coord_z, coord_y, coord_x};
        end
        if (accept)
        begin
            vt_rd_reg <= vtab_mem[vertex_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (accept)
        begin
            vis_rd_reg <= vis_mem[vertex_index[mbbcd_pkg::INDEX_W-1:mbbcd_pkg::VIS_BIT_W]];
        end
    end

    // A corner right behind one that wrote the same row sees the written word.
    always_comb
    begin
        if (fwd_valid_reg &&
            fwd_row_reg == s1_index_reg[mbbcd_pkg::INDEX_W-1:mbbcd_pkg::VIS_BIT_W])
        begin
            row = fwd_data_reg;
        end
        else
        begin
            row = vis_rd_reg;
        end
        seen     = row[s1_index_reg[mbbcd_pkg::VIS_BIT_W-1:0]];
        in_range = {1'b0, s1_index_reg} < vcount_reg;
        vx       = vt_rd_reg[CW-1:0];
        vy       = vt_rd_reg[2*CW-1:CW];
        vz       = vt_rd_reg[3*CW-1:2*CW];
    end

    always_comb
    begin
        case (sq_cnt_reg)
            3'd0:
            begin
                axis_max = {max_x_reg[CW-1], max_x_reg};
                axis_min = {min_x_reg[CW-1], min_x_reg};
            end
            3'd1:
            begin
                axis_max = {max_y_reg[CW-1], max_y_reg};
                axis_min = {min_y_reg[CW-1], min_y_reg};
            end
            default:
            begin
                axis_max = {max_z_reg[CW-1], max_z_reg};
                axis_min = {min_z_reg[CW-1], min_z_reg};
            end
        endcase
        axis_diff  = axis_max - axis_min;
        sum_x      = {max_x_reg[CW-1], max_x_reg} + {min_x_reg[CW-1], min_x_reg};
        sum_y      = {max_y_reg[CW-1], max_y_reg} + {min_y_reg[CW-1], min_y_reg};
        sum_z      = {max_z_reg[CW-1], max_z_reg} + {min_z_reg[CW-1], min_z_reg};
        sum_final  = sum_reg + {2'b00, sq_reg};
        rem_trial  = {rem_reg, rad_reg[mbbcd_pkg::SUM_W-1:mbbcd_pkg::SUM_W-2]};
        root_trial = {2'b00, root_reg, 2'b01};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        s1_valid_next  = accept && (cmd == mbbcd_pkg::CMD_CORNER);
        fwd_valid_next = 1'b0;
        vis_we         = 1'b0;
        vis_waddr      = s1_index_reg[mbbcd_pkg::INDEX_W-1:mbbcd_pkg::VIS_BIT_W];
        vis_wdata      = row | (mbbcd_pkg::VIS_WORD'(1) << s1_index_reg[mbbcd_pkg::VIS_BIT_W-1:0]);
        dcount_next    = dcount_reg;
        range_err_next = range_err_reg;
        min_x_next     = min_x_reg;
        min_y_next     = min_y_reg;
        min_z_next     = min_z_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        max_z_next     = max_z_reg;
        sq_cnt_next    = sq_cnt_reg;
        ext_next       = ext_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        iter_next      = iter_reg;
        done_next      = 1'b0;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        diag_next      = diag_reg;
        status_next    = status_reg;

        unique case (state_reg)
            mbbcd_pkg::ST_CLEAR:
            begin
                vis_we       = 1'b1;
                vis_waddr    = clr_cnt_reg;
                vis_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == mbbcd_pkg::VIS_ROW_W'(mbbcd_pkg::VIS_ROWS - 1))
                begin
                    state_next = mbbcd_pkg::ST_RUN;
                end
            end

            mbbcd_pkg::ST_RUN:
            begin
                if (s1_valid_reg)
                begin
                    if (!in_range)
                    begin
                        range_err_next = 1'b1;
                    end
                    if (!seen)
                    begin
                        vis_we         = 1'b1;
                        fwd_valid_next = 1'b1;
                        dcount_next    = dcount_reg + 1'b1;
                        if (in_range)
                        begin
                            if (vx < min_x_reg) min_x_next = vx;
                            if (vy < min_y_reg) min_y_next = vy;
                            if (vz < min_z_reg) min_z_next = vz;
                            if (vx > max_x_reg) max_x_next = vx;
                            if (vy > max_y_reg) max_y_next = vy;
                            if (vz > max_z_reg) max_z_next = vz;
                        end
                    end
                    if (s1_last_reg)
                    begin
                        if (dcount_next < mbbcd_pkg::MIN_DISTINCT || range_err_next)
                        begin
                            done_next   = 1'b1;
                            cx_next     = '0;
                            cy_next     = '0;
                            cz_next     = '0;
                            diag_next   = '0;
                            status_next = (dcount_next < mbbcd_pkg::MIN_DISTINCT)
                                        ? mbbcd_pkg::STATUS_TOO_FEW
                                        : mbbcd_pkg::STATUS_OUT_RANGE;
                            state_next  = mbbcd_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            sq_cnt_next = '0;
                            sum_next    = '0;
                            state_next  = mbbcd_pkg::ST_SQUARE;
                        end
                    end
                end
            end

            mbbcd_pkg::ST_SQUARE:
            begin
                // Extent, square and accumulate run as a three-deep chain over the axes.
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg < 3'd3)
                begin
                    ext_next = axis_diff[CW-1:0];
                end
                if (sq_cnt_reg >= 3'd1 && sq_cnt_reg <= 3'd3)
                begin
                    sq_next = {{CW{1'b0}}, ext_reg} * {{CW{1'b0}}, ext_reg};
                end
                if (sq_cnt_reg == 3'd2 || sq_cnt_reg == 3'd3)
                begin
                    sum_next = sum_final;
                end
                if (sq_cnt_reg == 3'd0)
                begin
                    cx_next = sum_x[CW:1];
                    cy_next = sum_y[CW:1];
                    cz_next = sum_z[CW:1];
                end
                if (sq_cnt_reg == 3'd4)
                begin
                    rad_next   = sum_final;
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = mbbcd_pkg::ST_ROOT;
                end
            end

            mbbcd_pkg::ST_ROOT:
            begin
                // One result bit per cycle, two radicand bits brought down each time.
                rad_next  = {rad_reg[mbbcd_pkg::SUM_W-3:0], 2'b00};
                iter_next = iter_reg + 1'b1;
                if (rem_trial >= root_trial)
                begin
                    rem_next  = mbbcd_pkg::REM_W'(rem_trial - root_trial);
                    root_next = {root_reg[mbbcd_pkg::DIAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_trial[mbbcd_pkg::REM_W-1:0];
                    root_next = {root_reg[mbbcd_pkg::DIAG_W-2:0], 1'b0};
                end
                if (iter_reg == mbbcd_pkg::STEP_W'(mbbcd_pkg::ROOT_STEPS - 1))
                begin
                    done_next   = 1'b1;
                    diag_next   = root_next;
                    status_next = mbbcd_pkg::STATUS_OK;
                    state_next  = mbbcd_pkg::ST_CLEAR;
                end
            end

            default:
            begin
                state_next = mbbcd_pkg::ST_CLEAR;
            end
        endcase

        // Each result closes the list.
        if (done_next)
        begin
            clr_cnt_next   = '0;
            dcount_next    = '0;
            range_err_next = 1'b0;
            min_x_next     = mbbcd_pkg::COORD_MOST_POS;
            min_y_next     = mbbcd_pkg::COORD_MOST_POS;
            min_z_next     = mbbcd_pkg::COORD_MOST_POS;
            max_x_next     = mbbcd_pkg::COORD_MOST_NEG;
            max_y_next     = mbbcd_pkg::COORD_MOST_NEG;
            max_z_next     = mbbcd_pkg::COORD_MOST_NEG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbbcd_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            vcount_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            dcount_reg    <= '0;
            range_err_reg <= 1'b0;
            min_x_reg     <= mbbcd_pkg::COORD_MOST_POS;
            min_y_reg     <= mbbcd_pkg::COORD_MOST_POS;
            min_z_reg     <= mbbcd_pkg::COORD_MOST_POS;
            max_x_reg     <= mbbcd_pkg::COORD_MOST_NEG;
            max_y_reg     <= mbbcd_pkg::COORD_MOST_NEG;
            max_z_reg     <= mbbcd_pkg::COORD_MOST_NEG;
            sq_cnt_reg    <= '0;
            iter_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_write)
            begin
                vcount_reg <= pwdata[mbbcd_pkg::COUNT_W-1:0];
            end
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            dcount_reg    <= dcount_next;
            range_err_reg <= range_err_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            min_z_reg     <= min_z_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            max_z_reg     <= max_z_next;
            sq_cnt_reg    <= sq_cnt_next;
            iter_reg      <= iter_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_index_reg <= vertex_index;
            s1_last_reg  <= last_corner;
        end
        fwd_row_reg  <= vis_waddr;
        fwd_data_reg <= vis_wdata;
        ext_reg      <= ext_next;
        sq_reg       <= sq_next;
        sum_reg      <= sum_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        diag_reg     <= diag_next;
        status_reg   <= status_next;
    end

endmodule

`default_nettype wire

// ===== hdl/mbbcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbbcd_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  start,
    input wire                                  busy,
    input wire                                  done,
    input wire [mbbcd_pkg::COORD_W-1:0]         center_x,
    input wire [mbbcd_pkg::COORD_W-1:0]         center_y,
    input wire [mbbcd_pkg::COORD_W-1:0]         center_z,
    input wire [mbbcd_pkg::DIAG_W-1:0]          diagonal_length,
    input wire [1:0]                            status
);

    // A result is only ever produced while the block refuses new words.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word shown while block was ready");

    // The bitmap sweep after each result keeps results apart.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Nothing accepted can finish in the very next cycle.
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result appeared directly after an accepted word");

    // Error results carry zero geometry.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != mbbcd_pkg::STATUS_OK) |->
        (center_x == '0 && center_y == '0 && center_z == '0 && diagonal_length == '0))
        else $error("error result carries non-zero geometry");

endmodule

bind mesh_bounding_box_center_diagonal mbbcd_checker u_mbbcd_checker (.*);

`default_nettype wire

// ===== tb/mbbcd_box_checker.sv =====
`timescale 1ns / 1ps

module mbbcd_box_checker
    import mbbcd_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire                          cmd,
    input  wire  [INDEX_W-1:0]           vertex_index,
    input  wire  signed [COORD_W-1:0]    coord_x,
    input  wire  signed [COORD_W-1:0]    coord_y,
    input  wire  signed [COORD_W-1:0]    coord_z,
    input  wire                          last_corner,
    input  wire                          done,
    input  wire  signed [COORD_W-1:0]    center_x,
    input  wire  signed [COORD_W-1:0]    center_y,
    input  wire  signed [COORD_W-1:0]    center_z,
    input  wire  [DIAG_W-1:0]            diagonal_length,
    input  wire  [1:0]                   status,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [APB_ADDR_W-1:0]        paddr,
    input  wire  [APB_DATA_W-1:0]        pwdata,
    input  wire                          pready,
    output int                           fail_count,
    output int                           pending
);

    typedef struct {
        logic signed [COORD_W-1:0] centre [3];
        logic [DIAG_W-1:0]         diag;
        logic [1:0]                st;
    } box_result_t;

    localparam longint unsigned DIAG_LIMIT = (64'd1 << DIAG_W) - 64'd1;

    logic signed [COORD_W-1:0] vert_mem [MAX_VERTICES][3];
    logic [MAX_VERTICES-1:0]   seen;
    int unsigned               n_distinct;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    bit                        bad_index;
    logic [COUNT_W-1:0]        vcount;
    box_result_t               boxq [$];
    int                        n_mismatch;

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        // Build the root one bit at a time from the top; t*t never overflows.
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    task automatic clear_list();
        int a;
        seen       = '0;
        n_distinct = 0;
        bad_index  = 1'b0;
        for (a = 0; a < 3; a++)
        begin
            lo[a] = COORD_MOST_POS;
            hi[a] = COORD_MOST_NEG;
        end
    endtask

    task automatic note_mismatch(input string what, input box_result_t want,
                                 input box_result_t got);
        fail_count++;
        n_mismatch++;
        if (n_mismatch <= 10)
        begin
            $display("%0t %s: expected c=(%0d,%0d,%0d) diag=%0d st=%0d",
                     $time, what, want.centre[0], want.centre[1], want.centre[2],
                     want.diag, want.st);
            $display("%0t %s: got      c=(%0d,%0d,%0d) diag=%0d st=%0d",
                     $time, what, got.centre[0], got.centre[1], got.centre[2],
                     got.diag, got.st);
        end
    endtask

    task automatic check_box();
        box_result_t want;
        box_result_t got;
        bit          bad;
        int          a;
        got.centre[0] = center_x;
        got.centre[1] = center_y;
        got.centre[2] = center_z;
        got.diag      = diagonal_length;
        got.st        = status;
        if (boxq.size() == 0)
        begin
            for (a = 0; a < 3; a++)
                want.centre[a] = '0;
            want.diag = '0;
            want.st   = '0;
            note_mismatch("result with no word outstanding", want, got);
            return;
        end
        want = boxq.pop_front();
        bad  = (want.st !== got.st) || (want.diag !== got.diag);
        for (a = 0; a < 3; a++)
            if (want.centre[a] !== got.centre[a])
                bad = 1'b1;
        if (bad)
            note_mismatch("box mismatch", want, got);
    endtask

    task automatic take_word();
        box_result_t              r;
        logic signed [COORD_W:0]  s;
        logic [COORD_W:0]         e;
        longint unsigned          ee;
        longint unsigned          acc;
        longint unsigned          root;
        logic signed [COORD_W-1:0] v;
        bit                       ok;
        int                       a;
        if (cmd == CMD_LOAD)
        begin
            vert_mem[vertex_index][0] = coord_x;
            vert_mem[vertex_index][1] = coord_y;
            vert_mem[vertex_index][2] = coord_z;
            return;
        end
        ok = {1'b0, vertex_index} < vcount;
        if (!ok)
            bad_index = 1'b1;
        // An index past vertex_count still counts as distinct, but adds nothing to the box.
        if (!seen[vertex_index])
        begin
            seen[vertex_index] = 1'b1;
            n_distinct++;
            if (ok)
                for (a = 0; a < 3; a++)
                begin
                    v = vert_mem[vertex_index][a];
                    if (v < lo[a])
                        lo[a] = v;
                    if (v > hi[a])
                        hi[a] = v;
                end
        end
        if (!last_corner)
            return;
        for (a = 0; a < 3; a++)
            r.centre[a] = '0;
        r.diag = '0;
        if (n_distinct < MIN_DISTINCT)
            r.st = STATUS_TOO_FEW;
        else if (bad_index)
            r.st = STATUS_OUT_RANGE;
        else
        begin
            acc = 0;
            for (a = 0; a < 3; a++)
            begin
                s           = hi[a] + lo[a];
                e           = hi[a] - lo[a];
                r.centre[a] = COORD_W'(s >>> 1);
                ee          = e;
                acc        += ee * ee;
            end
            root = floor_sqrt(acc);
            if (root > DIAG_LIMIT)
                root = DIAG_LIMIT;
            r.diag = DIAG_W'(root);
            r.st   = STATUS_OK;
        end
        clear_list();
        boxq = {boxq, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount     = '0;
            fail_count = 0;
            n_mismatch = 0;
            clear_list();
            boxq.delete();
            pending    = 0;
        end
        else
        begin
            if (done)
                check_box();
            if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT)
                vcount = pwdata[COUNT_W-1:0];
            if (start && !busy)
                take_word();
            pending = boxq.size();
        end
    end

endmodule

// ===== tb/mesh_bounding_box_center_diagonal_tb.sv =====
`timescale 1ns / 1ps

module mesh_bounding_box_center_diagonal_tb;
    import mbbcd_pkg::*;

    localparam int ITEMS      = 1900;
    localparam int CALM_ITEMS = 150;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      cmd          = CMD_LOAD;
    logic [INDEX_W-1:0]        vertex_index = '0;
    logic signed [COORD_W-1:0] coord_x      = '0;
    logic signed [COORD_W-1:0] coord_y      = '0;
    logic signed [COORD_W-1:0] coord_z      = '0;
    logic                      last_corner  = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr        = '0;
    logic [APB_DATA_W-1:0]     pwdata       = '0;

    wire                       busy;
    wire                       done;
    wire signed [COORD_W-1:0]  center_x;
    wire signed [COORD_W-1:0]  center_y;
    wire signed [COORD_W-1:0]  center_z;
    wire [DIAG_W-1:0]          diagonal_length;
    wire [1:0]                 status;
    wire [APB_DATA_W-1:0]      prdata;
    wire                       pready;

    int                        fail_count;
    int                        pending;

    logic [COUNT_W-1:0]        vc_now = '0;
    bit                        loaded [MAX_VERTICES];
    logic [INDEX_W-1:0]        filled [$];
    bit                        idle_on = 1'b1;
    int                        n_sent  = 0;
    int                        vc_plan [10] = '{1024, 0, 1, 3, 1024, -1, 2, 1023, -1, 1024};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mesh_bounding_box_center_diagonal dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .last_corner(last_corner), .done(done),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .diagonal_length(diagonal_length), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mbbcd_box_checker box_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .last_corner(last_corner), .done(done),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .diagonal_length(diagonal_length), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] c;
        c = COORD_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c = COORD_MOST_POS;
            1:       c = COORD_MOST_NEG;
            2:       c = c >>> 14;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_slot();
        if ($urandom_range(0, 1))
            return INDEX_W'($urandom_range(0, 63));
        return INDEX_W'($urandom_range(0, MAX_VERTICES - 1));
    endfunction

    // A corner below vertex_count must name a slot that has been loaded.
    function automatic logic [INDEX_W-1:0] pick_corner(input bit tidy);
        logic [INDEX_W-1:0] k;
        k = INDEX_W'($urandom_range(0, MAX_VERTICES - 1));
        if (tidy || $urandom_range(0, 1))
            for (int t = 0; t < 8; t++)
            begin
                k = filled[$urandom_range(0, filled.size() - 1)];
                if ({1'b0, k} < vc_now)
                    break;
            end
        if ({1'b0, k} < vc_now && !loaded[k])
            k = filled[$urandom_range(0, filled.size() - 1)];
        return k;
    endfunction

    // Called just after a rising edge; returns after the word is taken, or after an idle gap.
    task automatic send_word(input logic c, input logic [INDEX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z, input logic lc);
        start        <= 1'b1;
        cmd          <= c;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        last_corner  <= lc;
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
        n_sent++;
        if (c == CMD_LOAD && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            filled      = {filled, idx};
        end
        if (n_sent >= ITEMS - CALM_ITEMS)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx);
        send_word(CMD_LOAD, idx, rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    endtask

    task automatic send_corner(input logic [INDEX_W-1:0] idx, input logic lc);
        send_word(CMD_CORNER, idx, rand_coord(), rand_coord(), rand_coord(), lc);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Before a register write: nothing outstanding, busy low, bitmap sweep over, then a wait.
    task automatic settle();
        wait_results();
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic write_count(input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_VERTEX_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vc_now = COUNT_W'(v);
    endtask

    task automatic run_list(input int len, input bit tidy);
        for (int k = 0; k < len; k++)
        begin
            if (tidy && $urandom_range(0, 15) == 0)
                send_load(pick_slot());
            send_corner(pick_corner(tidy), k == len - 1);
        end
    endtask

    initial
    begin
        int p;
        int v;
        int kind;
        int stop_at;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        settle();
        write_count(MAX_VERTICES - 1);

        send_word(CMD_LOAD, 0, COORD_MOST_POS, COORD_MOST_POS, COORD_MOST_POS, 1'b1);
        send_word(CMD_LOAD, 1, COORD_MOST_NEG, COORD_MOST_NEG, COORD_MOST_NEG, 1'b0);
        send_word(CMD_LOAD, 2, '0, '0, '0, 1'b1);
        send_word(CMD_LOAD, 3, COORD_W'(1), COORD_W'(-1), COORD_W'(24'h123456), 1'b0);
        send_load(INDEX_W'(MAX_VERTICES - 1));
        // Widest box possible; the centre of each axis rounds down to -1.
        send_corner(0, 1'b0);
        send_corner(1, 1'b0);
        send_corner(2, 1'b1);
        // A repeated index leaves only two distinct vertices.
        send_corner(0, 1'b0);
        send_corner(0, 1'b0);
        send_corner(1, 1'b1);
        // One index equal to vertex_count, so out of range, among three good ones.
        send_corner(0, 1'b0);
        send_corner(INDEX_W'(MAX_VERTICES - 1), 1'b0);
        send_corner(1, 1'b0);
        send_corner(2, 1'b1);
        // Too few distinct vertices takes priority over the range error.
        send_corner(INDEX_W'(MAX_VERTICES - 1), 1'b0);
        send_corner(INDEX_W'(MAX_VERTICES - 1), 1'b1);
        send_corner(2, 1'b1);
        // A load inside a list, read by the corner right behind it.
        send_corner(3, 1'b0);
        send_word(CMD_LOAD, 4, COORD_W'(-5), COORD_W'(7), COORD_MOST_NEG, 1'b1);
        send_corner(4, 1'b0);
        send_corner(2, 1'b1);

        p = 0;
        while (n_sent < ITEMS)
        begin
            settle();
            v = vc_plan[p % 10];
            if (v < 0)
                v = $urandom_range(4, MAX_VERTICES);
            write_count(v);
            stop_at = n_sent + 190;
            while (n_sent < stop_at && n_sent < ITEMS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 25)
                    repeat ($urandom_range(1, 6))
                        send_load(pick_slot());
                else if (kind < 80)
                    run_list($urandom_range(3, 10), 1'b1);
                else
                    run_list($urandom_range(1, 4), 1'b0);
                if ($urandom_range(0, 24) == 0)
                    wait_results();
            end
            p++;
        end

        wait_results();
        repeat (100)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("mesh_bounding_box_center_diagonal_tb passed");
        else
            $display("mesh_bounding_box_center_diagonal_tb failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("mesh_bounding_box_center_diagonal_tb failed");
        $finish;
    end

endmodule

// ===== mesh_bounding_box_center_diagonal.f =====
hdl/mbbcd_pkg.sv
hdl/mesh_bounding_box_center_diagonal.sv
hdl/mbbcd_checker.sv
tb/mbbcd_box_checker.sv
tb/mesh_bounding_box_center_diagonal_tb.sv
